// File: hw/rtl/radix_limb_bignum_subtract_assert.svh
// ----------------------------------------------------------------------------
// radix_limb_bignum_subtract_assert.svh
// assertion macros used by the checker file of the limb subtractor
// ----------------------------------------------------------------------------
`ifndef RADIX_LIMB_BIGNUM_SUBTRACT_ASSERT_SVH
`define RADIX_LIMB_BIGNUM_SUBTRACT_ASSERT_SVH

// property checked on every clock edge outside reset
`define RLBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define RLBS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg
// types and constants of the radix limb subtractor
// ----------------------------------------------------------------------------
package rlbs_pkg;

  localparam int unsigned LIMB_W = 30;
  localparam logic [LIMB_W-1:0] RADIX_RESET = 30'd1000000000;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FETCH,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ORD_EQUAL     = 2'd0,
    ORD_A_LARGER  = 2'd1,
    ORD_A_SMALLER = 2'd2
  } order_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_limb;
  } stat_t;

endpackage

// File: hw/rtl/rlbs_if.sv
// ----------------------------------------------------------------------------
// rlbs_if
// valid/ready channels of the limb subtractor
// ----------------------------------------------------------------------------
interface rlbs_in_if;
  import rlbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] limb_a;
  logic [LIMB_W-1:0] limb_b;
  logic              last_in;

  modport source (output valid, limb_a, limb_b, last_in, input ready);
  modport sink (input valid, limb_a, limb_b, last_in, output ready);
endinterface

interface rlbs_out_if;
  import rlbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] diff_limb;
  logic              negative;
  logic              last_out;

  modport source (output valid, diff_limb, negative, last_out, input ready);
  modport sink (input valid, diff_limb, negative, last_out, output ready);
endinterface

interface rlbs_cfg_if;
  import rlbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] radix;

  modport source (output valid, radix, input ready);
  modport sink (input valid, radix, output ready);
endinterface

// File: hw/rtl/rlbs_ram.sv
// ----------------------------------------------------------------------------
// rlbs_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rlbs_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/rlbs_datapath.sv
// ----------------------------------------------------------------------------
// rlbs_datapath
// limb store, order compare, ripple-borrow digit unit and output register
// ----------------------------------------------------------------------------
module rlbs_datapath #(
  parameter int unsigned MAX_LIMBS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rlbs_pkg::cmd_t             cmd,
  output rlbs_pkg::stat_t            stat,
  input  logic [rlbs_pkg::LIMB_W-1:0] in_limb_a,
  input  logic [rlbs_pkg::LIMB_W-1:0] in_limb_b,
  input  logic                       in_last,
  input  logic                       cfg_we,
  input  logic [rlbs_pkg::LIMB_W-1:0] cfg_radix,
  output logic [rlbs_pkg::LIMB_W-1:0] out_diff_limb,
  output logic                       out_negative,
  output logic                       out_last
);
  import rlbs_pkg::*;

  localparam int unsigned ADDR_W = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_LIMBS + 1);

  logic [CNT_W-1:0]    count_r, count_nxt;
  order_t              order_r, order_nxt;
  logic [LIMB_W-1:0]   radix_r;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic                neg_r, neg_nxt;
  logic                borrow_r, borrow_nxt;
  logic [LIMB_W-1:0]   out_limb_r, out_limb_nxt;
  logic                out_neg_r, out_neg_nxt;
  logic                out_last_r, out_last_nxt;

  logic                write_ok;
  logic                ram_we;
  logic [CNT_W-1:0]    n_cnt;
  logic [CNT_W-1:0]    n_less;
  order_t              order_upd;
  logic [2*LIMB_W-1:0] ram_rdata;
  logic [LIMB_W-1:0]   rd_a, rd_b, x_op, y_op;
  logic [LIMB_W:0]     need;
  logic [LIMB_W+1:0]   diff;
  logic                borrow_out;
  logic [LIMB_W-1:0]   digit;

  rlbs_ram #(
    .WIDTH (2 * LIMB_W),
    .DEPTH (MAX_LIMBS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({in_limb_a, in_limb_b}),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign rd_a = ram_rdata[2*LIMB_W-1:LIMB_W];
  assign rd_b = ram_rdata[LIMB_W-1:0];

  // load side: store pair, track first differing limb
  always_comb begin
    write_ok = count_r < CNT_W'(MAX_LIMBS);
    ram_we   = cmd.load && write_ok;
    n_cnt    = write_ok ? count_r + 1'b1 : count_r;
    n_less   = n_cnt - 1'b1;
    order_upd = order_r;
    if (write_ok && order_r == ORD_EQUAL) begin
      if (in_limb_a > in_limb_b) begin
        order_upd = ORD_A_LARGER;
      end else if (in_limb_a < in_limb_b) begin
        order_upd = ORD_A_SMALLER;
      end
    end
  end

  // digit unit: larger minus smaller with ripple borrow
  always_comb begin
    x_op       = neg_r ? rd_b : rd_a;
    y_op       = neg_r ? rd_a : rd_b;
    need       = {1'b0, y_op} + {{LIMB_W{1'b0}}, borrow_r};
    diff       = {2'b00, x_op} - {1'b0, need};
    borrow_out = diff[LIMB_W+1];
    // raising the digit by radix, modulo the limb width
    digit      = borrow_out ? diff[LIMB_W-1:0] + radix_r : diff[LIMB_W-1:0];
  end

  always_comb begin
    count_nxt    = count_r;
    order_nxt    = order_r;
    rd_addr_nxt  = rd_addr_r;
    neg_nxt      = neg_r;
    borrow_nxt   = borrow_r;
    out_limb_nxt = out_limb_r;
    out_neg_nxt  = out_neg_r;
    out_last_nxt = out_last_r;
    if (cmd.load) begin
      if (in_last) begin
        // operand done: point at the least significant limb, clear for next
        rd_addr_nxt = n_less[ADDR_W-1:0];
        neg_nxt     = (order_upd == ORD_A_SMALLER);
        borrow_nxt  = 1'b0;
        count_nxt   = '0;
        order_nxt   = ORD_EQUAL;
      end else begin
        count_nxt = n_cnt;
        order_nxt = order_upd;
      end
    end
    if (cmd.calc) begin
      out_limb_nxt = digit;
      out_neg_nxt  = neg_r;
      out_last_nxt = (rd_addr_r == '0);
      borrow_nxt   = borrow_out;
      rd_addr_nxt  = rd_addr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      order_r <= ORD_EQUAL;
      radix_r <= RADIX_RESET;
    end else begin
      count_r <= count_nxt;
      order_r <= order_nxt;
      if (cfg_we) begin
        radix_r <= cfg_radix;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    neg_r      <= neg_nxt;
    borrow_r   <= borrow_nxt;
    out_limb_r <= out_limb_nxt;
    out_neg_r  <= out_neg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.last_limb = out_last_r;
  assign out_diff_limb  = out_limb_r;
  assign out_negative   = out_neg_r;
  assign out_last       = out_last_r;

endmodule

// File: hw/rtl/rlbs_ctrl.sv
// ----------------------------------------------------------------------------
// rlbs_ctrl
// sequencer for load, fetch, digit and output phases
// ----------------------------------------------------------------------------
module rlbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  input  logic            out_ready,
  input  rlbs_pkg::stat_t stat,
  output logic            in_ready,
  output logic            out_valid,
  output rlbs_pkg::cmd_t  cmd
);
  import rlbs_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready) begin
          state_nxt = stat.last_limb ? ST_LOAD : ST_CALC;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FETCH: begin
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/radix_limb_bignum_subtract.sv
// ----------------------------------------------------------------------------
// radix_limb_bignum_subtract
// multiprecision subtractor over limbs in a configurable radix
// ----------------------------------------------------------------------------
// channel  dir  word
// in_ch    in   limb_a, limb_b, last_in (most significant pair first)
// out_ch   out  diff_limb, negative, last_out (least significant limb first)
// cfg_ch   in   radix, always ready
//
// loading takes one pair per cycle; the pair with last_in ends the operand
// then a fetch state for the registered ram read; for each result word,
// digit compute into the output register, then the output handshake
// out_ch stalls hold the word; in_ch is not ready during the subtract pass
// reset is synchronous; the limb store needs no clearing pass
// ----------------------------------------------------------------------------
module radix_limb_bignum_subtract #(
  parameter int unsigned MAX_LIMBS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  rlbs_in_if.sink          in_ch,
  rlbs_out_if.source       out_ch,
  rlbs_cfg_if.sink         cfg_ch
);
  import rlbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  rlbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_in),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  rlbs_datapath #(
    .MAX_LIMBS (MAX_LIMBS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_limb_a     (in_ch.limb_a),
    .in_limb_b     (in_ch.limb_b),
    .in_last       (in_ch.last_in),
    .cfg_we        (cfg_we),
    .cfg_radix     (cfg_ch.radix),
    .out_diff_limb (out_ch.diff_limb),
    .out_negative  (out_ch.negative),
    .out_last      (out_ch.last_out)
  );

endmodule

// File: hw/rtl/rlbs_checker.sv
// ----------------------------------------------------------------------------
// rlbs_checker
// port-level checks of the limb subtractor, bound to the top level
// ----------------------------------------------------------------------------
`include "radix_limb_bignum_subtract_assert.svh"

module rlbs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_last,
  input logic [rlbs_pkg::LIMB_W-1:0] out_limb
);

  // no loading while a result word is offered
  `RLBS_NEVER(a_no_overlap, in_ready && out_valid, "input ready during output")

  // a stalled result word holds
  `RLBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_limb),
    "stalled output word changed")

  // the closing pair starts the subtract pass
  `RLBS_ASSERT(a_last_in_busy, in_valid && in_ready && in_last |=> !in_ready && !out_valid,
    "no fetch cycle after closing pair")

  // inside a result burst the input stays closed
  `RLBS_ASSERT(a_burst_closed, out_valid && out_ready && !out_last |=> !in_ready,
    "input reopened before last result word")

  // after the final word the block loads again
  `RLBS_ASSERT(a_back_to_load, out_valid && out_ready && out_last |=> in_ready,
    "not ready after final result word")

endmodule

bind radix_limb_bignum_subtract rlbs_checker u_rlbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_in),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_out),
  .out_limb  (out_ch.diff_limb)
);
